[sv/tli_pkg.sv]
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants of the tensor layout index block
// Field widths, layout and status codes, register indexes and the job word
// that the front end hands to the multiply pipeline.
// ----------------------------------------------------------------------------
package tli_pkg;

	localparam int COORD_W    = 12;
	localparam int SIZE_W     = 13;
	localparam int INDEX_W    = 60;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SIZE_W;
	localparam int NUM_DIMS   = 5;
	localparam int NUM_LEVELS = 4;

	localparam int V1_W = COORD_W + SIZE_W;
	localparam int V2_W = V1_W + SIZE_W;
	localparam int V3_W = V2_W + SIZE_W;

	localparam int BLK_16 = 16;
	localparam int BLK_24 = 24;
	localparam int BLK_13 = 13;
	localparam int BLK_4  = 4;
	localparam int BLK_2  = 2;

	localparam int RECIP_W = 16;
	localparam logic [RECIP_W-1:0] RECIP_13 = 16'd5042;
	localparam logic [RECIP_W-1:0] RECIP_24 = 16'd2731;

	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_1  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_3  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_4  = 3'd5;

	typedef enum logic [3:0] {
		LAYOUT_XB       = 4'd0,
		LAYOUT_BX       = 4'd1,
		LAYOUT_OI       = 4'd2,
		LAYOUT_IO       = 4'd3,
		LAYOUT_IO_I13   = 4'd4,
		LAYOUT_IO_I2    = 4'd5,
		LAYOUT_YXFB     = 4'd6,
		LAYOUT_BYXF     = 4'd7,
		LAYOUT_OIYX     = 4'd8,
		LAYOUT_OYXI_O16 = 4'd9,
		LAYOUT_BFYX     = 4'd10,
		LAYOUT_FYXB     = 4'd11,
		LAYOUT_BYXF_B24 = 4'd12,
		LAYOUT_YXOI_O4  = 4'd13
	} layout_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_RANGE  = 2'd1,
		STATUS_LAYOUT = 2'd2
	} status_t;

	// index = a0 + m0*(a1 + m1*(a2 + m2*(a3 + m3*a4)))
	typedef struct packed {
		logic [NUM_LEVELS:0][COORD_W-1:0]  addend;
		logic [NUM_LEVELS-1:0][SIZE_W-1:0] scale;
		status_t                           status;
	} job_t;

endpackage

[sv/tli_if.sv]
// ----------------------------------------------------------------------------
// tli_if: channel interfaces of the tensor layout index block
// Coordinate input, index output and configuration write channels, each a
// valid/ready pair with its payload.
// ----------------------------------------------------------------------------
interface tli_in_if import tli_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] coord_0;
	logic [COORD_W-1:0] coord_1;
	logic [COORD_W-1:0] coord_2;
	logic [COORD_W-1:0] coord_3;
	logic [COORD_W-1:0] coord_4;

	modport source (output valid, coord_0, coord_1, coord_2, coord_3, coord_4, input ready);
	modport sink (input valid, coord_0, coord_1, coord_2, coord_3, coord_4, output ready);
	modport monitor (input valid, ready, coord_0, coord_1, coord_2, coord_3, coord_4);
endinterface

interface tli_out_if import tli_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] element_index;
	status_t            status;

	modport source (output valid, element_index, status, input ready);
	modport sink (input valid, element_index, status, output ready);
	modport monitor (input valid, ready, element_index, status);
endinterface

interface tli_cfg_if import tli_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport monitor (input valid, ready, index, data);
endinterface

[sv/tli_front.sv]
// ----------------------------------------------------------------------------
// tli_front: configuration registers and item classification
// Checks each coordinate beat against the sizes and the layout code, and maps
// the layout onto the addends and scales of a four-level multiply chain.
// ----------------------------------------------------------------------------
module tli_front import tli_pkg::*; #(
	parameter int DIM_MAX = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	tli_cfg_if.sink    cfg,
	tli_in_if.sink     coord_in,
	output job_t       job,
	output logic       job_valid,
	input  logic       job_ready
);

	layout_t                          layout_q;
	logic [NUM_DIMS-1:0][SIZE_W-1:0]  size_q;
	logic [SIZE_W-1:0]                size_wr;
	logic [NUM_DIMS-1:0][COORD_W-1:0] p;
	logic [NUM_DIMS-1:0]              over;
	logic                             range_err;

	logic [COORD_W+RECIP_W-1:0] prod13;
	logic [COORD_W+RECIP_W-1:0] prod24;
	logic [COORD_W-1:0]         q13;
	logic [COORD_W-1:0]         q24;
	logic [COORD_W-1:0]         r13;
	logic [COORD_W-1:0]         r24;

	assign cfg.ready = 1'b1;

	always_comb begin
		if (32'(cfg.data) > DIM_MAX) begin
			size_wr = SIZE_W'(DIM_MAX);
		end else begin
			size_wr = cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= LAYOUT_XB;
			for (int i = 0; i < NUM_DIMS; i++) begin
				size_q[i] <= SIZE_W'(1);
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LAYOUT: layout_q  <= layout_t'(cfg.data[3:0]);
				REG_DIM_0:  size_q[0] <= size_wr;
				REG_DIM_1:  size_q[1] <= size_wr;
				REG_DIM_2:  size_q[2] <= size_wr;
				REG_DIM_3:  size_q[3] <= size_wr;
				REG_DIM_4:  size_q[4] <= size_wr;
				default: begin
				end
			endcase
		end
	end

	assign p[0] = coord_in.coord_0;
	assign p[1] = coord_in.coord_1;
	assign p[2] = coord_in.coord_2;
	assign p[3] = coord_in.coord_3;
	assign p[4] = coord_in.coord_4;

	always_comb begin
		for (int i = 0; i < NUM_DIMS; i++) begin
			over[i] = ({1'b0, p[i]} >= size_q[i]);
		end
	end
	assign range_err = |over;

	assign prod13 = p[1] * RECIP_13;
	assign prod24 = p[0] * RECIP_24;
	assign q13    = prod13[COORD_W+RECIP_W-1:RECIP_W];
	assign q24    = prod24[COORD_W+RECIP_W-1:RECIP_W];
	assign r13    = p[1] - COORD_W'(q13 * COORD_W'(BLK_13));
	assign r24    = p[0] - COORD_W'(q24 * COORD_W'(BLK_24));

	always_comb begin
		job = '0;
		case (layout_q)
			LAYOUT_XB: begin
				job.addend[0] = p[0]; job.scale[0] = size_q[0];
				job.addend[1] = p[2];
			end
			LAYOUT_BX: begin
				job.addend[0] = p[2]; job.scale[0] = size_q[2];
				job.addend[1] = p[0];
			end
			LAYOUT_OI: begin
				job.addend[0] = p[2]; job.scale[0] = size_q[2];
				job.addend[1] = p[1];
			end
			LAYOUT_IO: begin
				job.addend[0] = p[1]; job.scale[0] = size_q[1];
				job.addend[1] = p[2];
			end
			LAYOUT_IO_I13: begin
				job.addend[0] = r13;  job.scale[0] = SIZE_W'(BLK_13);
				job.addend[1] = p[2]; job.scale[1] = size_q[2];
				job.addend[2] = q13;
			end
			LAYOUT_IO_I2: begin
				job.addend[0] = COORD_W'(p[1][0]); job.scale[0] = SIZE_W'(BLK_2);
				job.addend[1] = p[2];              job.scale[1] = size_q[2];
				job.addend[2] = p[1] >> 1;
			end
			LAYOUT_YXFB: begin
				job.addend[0] = p[0]; job.scale[0] = size_q[0];
				job.addend[1] = p[1]; job.scale[1] = size_q[1];
				job.addend[2] = p[2]; job.scale[2] = size_q[2];
				job.addend[3] = p[3];
			end
			LAYOUT_BYXF: begin
				job.addend[0] = p[1]; job.scale[0] = size_q[1];
				job.addend[1] = p[2]; job.scale[1] = size_q[2];
				job.addend[2] = p[3]; job.scale[2] = size_q[3];
				job.addend[3] = p[0];
			end
			LAYOUT_OIYX: begin
				job.addend[0] = p[3]; job.scale[0] = size_q[3];
				job.addend[1] = p[4]; job.scale[1] = size_q[4];
				job.addend[2] = p[2]; job.scale[2] = size_q[2];
				job.addend[3] = p[1];
			end
			LAYOUT_OYXI_O16: begin
				job.addend[0] = COORD_W'(p[1][3:0]); job.scale[0] = SIZE_W'(BLK_16);
				job.addend[1] = p[2];                job.scale[1] = size_q[2];
				job.addend[2] = p[3];                job.scale[2] = size_q[3];
				job.addend[3] = p[4];                job.scale[3] = size_q[4];
				job.addend[4] = p[1] >> 4;
			end
			LAYOUT_BFYX: begin
				job.addend[0] = p[2]; job.scale[0] = size_q[2];
				job.addend[1] = p[3]; job.scale[1] = size_q[3];
				job.addend[2] = p[1]; job.scale[2] = size_q[1];
				job.addend[3] = p[0];
			end
			LAYOUT_FYXB: begin
				job.addend[0] = p[0]; job.scale[0] = size_q[0];
				job.addend[1] = p[2]; job.scale[1] = size_q[2];
				job.addend[2] = p[3]; job.scale[2] = size_q[3];
				job.addend[3] = p[1];
			end
			LAYOUT_BYXF_B24: begin
				job.addend[0] = r24;  job.scale[0] = SIZE_W'(BLK_24);
				job.addend[1] = p[1]; job.scale[1] = size_q[1];
				job.addend[2] = p[2]; job.scale[2] = size_q[2];
				job.addend[3] = p[3]; job.scale[3] = size_q[3];
				job.addend[4] = q24;
			end
			LAYOUT_YXOI_O4: begin
				job.addend[0] = COORD_W'(p[1][1:0]); job.scale[0] = SIZE_W'(BLK_4);
				job.addend[1] = p[2];                job.scale[1] = size_q[2];
				job.addend[2] = p[1] >> 2;           job.scale[2] = size_q[1] >> 2;
				job.addend[3] = p[3];                job.scale[3] = size_q[3];
				job.addend[4] = p[4];
			end
			default: begin
				job.status = STATUS_LAYOUT;
			end
		endcase
		if (job.status == STATUS_OK && range_err) begin
			job        = '0;
			job.status = STATUS_RANGE;
		end
	end

	assign job_valid      = coord_in.valid;
	assign coord_in.ready = job_ready;

endmodule

[sv/tli_queue.sv]
// ----------------------------------------------------------------------------
// tli_queue: job queue between the front end and the multiply pipeline
// Small first-in first-out buffer that lets either side stall on its own.
// ----------------------------------------------------------------------------
module tli_queue import tli_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic wr_valid,
	output logic wr_ready,
	output job_t rd_job,
	output logic rd_valid,
	input  logic rd_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t              entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/tli_back.sv]
// ----------------------------------------------------------------------------
// tli_back: multiply-accumulate pipeline of the tensor layout index block
// Evaluates the nested index formula one level per stage, innermost first;
// the last stage is the output register.
// ----------------------------------------------------------------------------
module tli_back import tli_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      job,
	input  logic      job_valid,
	output logic      job_ready,
	tli_out_if.source index_out
);

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic                 rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [V1_W-1:0]      v_s1;
	logic [2:0][COORD_W-1:0] add_s1;
	logic [2:0][SIZE_W-1:0]  scl_s1;
	status_t              st_s1;

	logic [V2_W-1:0]      v_s2;
	logic [1:0][COORD_W-1:0] add_s2;
	logic [1:0][SIZE_W-1:0]  scl_s2;
	status_t              st_s2;

	logic [V3_W-1:0]      v_s3;
	logic [COORD_W-1:0]   add_s3;
	logic [SIZE_W-1:0]    scl_s3;
	status_t              st_s3;

	logic [INDEX_W-1:0]   idx_s4;
	status_t              st_s4;

	logic [V1_W-1:0]        prod1;
	logic [V2_W-1:0]        prod2;
	logic [V3_W-1:0]        prod3;
	logic [SIZE_W+V3_W-1:0] prod4;

	assign rdy_s4    = !vld_s4 || index_out.ready;
	assign rdy_s3    = !vld_s3 || rdy_s4;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign job_ready = rdy_s1;

	assign prod1 = job.scale[3] * job.addend[4];
	assign prod2 = scl_s1[2] * v_s1;
	assign prod3 = scl_s2[1] * v_s2;
	assign prod4 = scl_s3 * v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= job_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && job_valid) begin
			v_s1   <= prod1 + V1_W'(job.addend[3]);
			add_s1 <= job.addend[2:0];
			scl_s1 <= job.scale[2:0];
			st_s1  <= job.status;
		end
		if (rdy_s2 && vld_s1) begin
			v_s2   <= prod2 + V2_W'(add_s1[2]);
			add_s2 <= add_s1[1:0];
			scl_s2 <= scl_s1[1:0];
			st_s2  <= st_s1;
		end
		if (rdy_s3 && vld_s2) begin
			v_s3   <= prod3 + V3_W'(add_s2[1]);
			add_s3 <= add_s2[0];
			scl_s3 <= scl_s2[0];
			st_s3  <= st_s2;
		end
		if (rdy_s4 && vld_s3) begin
			idx_s4 <= INDEX_W'(prod4) + INDEX_W'(add_s3);
			st_s4  <= st_s3;
		end
	end

	assign index_out.valid         = vld_s4;
	assign index_out.element_index = idx_s4;
	assign index_out.status        = st_s4;

endmodule

[sv/tensor_layout_index.sv]
// ----------------------------------------------------------------------------
// tensor_layout_index: linear element index for fourteen tensor layouts
// Top level: front end, job queue and multiply pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   cfg       write channel; index 0 sets the layout code, 1 to 5 the sizes of
//             coordinates 0 to 4 (saturated to DIM_MAX). Always ready; write
//             only while no beat is in flight.
//   coord_in  one beat per position, coord_0 to coord_4.
//   index_out one beat per position: element_index and status (ok, position
//             out of range, unsupported layout; index 0 on any error).
// Path: an accepted coordinate beat is registered in the job queue, then
//   once per level of the nested multiply-add chain in the back pipeline,
//   whose last stage holds its result beat.
// Throughput: one beat per cycle unless stalled; one multiplier per stage.
// Stall: a stalled receiver holds the output beat; the pipeline and the
//   QUEUE_DEPTH entry queue keep filling until full, then coord_in.ready drops.
// Reset: layout 0, all sizes 1, pipeline and queue empty.
// ----------------------------------------------------------------------------
module tensor_layout_index import tli_pkg::*; #(
	parameter int DIM_MAX     = 4096,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	tli_cfg_if.sink cfg,
	tli_in_if.sink  coord_in,
	tli_out_if.source index_out
);

	job_t front_job;
	logic front_valid;
	logic front_ready;
	job_t back_job;
	logic back_valid;
	logic back_ready;

	tli_front #(
		.DIM_MAX (DIM_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.coord_in  (coord_in),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	tli_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_job   (front_job),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_job   (back_job),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	tli_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.index_out (index_out)
	);

endmodule

[sv/tli_checker.sv]
// ----------------------------------------------------------------------------
// tli_checker: port-level checks of the tensor layout index block
// Watches the configuration and result channels and is bound to the top.
// ----------------------------------------------------------------------------
module tli_checker import tli_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	tli_cfg_if.sink   cfg,
	tli_out_if.source index_out
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		index_out.valid |-> (index_out.status == STATUS_OK ||
			index_out.status == STATUS_RANGE || index_out.status == STATUS_LAYOUT))
		else $error("result beat carries an undefined status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(index_out.valid && index_out.status != STATUS_OK) |->
			(index_out.element_index == '0))
		else $error("error result beat carries a nonzero index");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> cfg.ready)
		else $error("configuration channel refused a write");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(index_out.valid && !index_out.ready) |=> (index_out.valid &&
			$stable(index_out.element_index) && $stable(index_out.status)))
		else $error("stalled result beat changed or vanished");

endmodule

bind tensor_layout_index tli_checker u_tli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg       (cfg),
	.index_out (index_out)
);
